@@ sv/gmug_pkg.sv @@
// ----------------------------------------------------------------------------
// gmug_pkg
// Shared sizes, state codes and helpers for the greedy min-union grouping core.
// ----------------------------------------------------------------------------
package gmug_pkg;

  localparam int FEATURES   = 32;
  localparam int WORDS      = 16;
  localparam int GROUP_SIZE = 4;

  localparam int FW  = 5;                     // feature index width
  localparam int WW  = 4;                     // word index width
  localparam int CW  = $clog2(FEATURES + 1);  // count width
  localparam int SAW = $clog2(FEATURES * WORDS);
  localparam int GW  = $clog2(GROUP_SIZE + 1);
  localparam int PW  = 7;                     // popcount of one word
  localparam int UCW = 11;                    // union count width
  localparam int FIW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int WIW = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_LIST, S_LREAD, S_SCAN, S_CMP, S_MRG, S_MWAIT, S_SWAP, S_OUT
  } state_t;

  function automatic logic [PW-1:0] pop64(input logic [63:0] x);
    logic [PW-1:0] n;
    n = '0;
    for (int k = 0; k < 64; k++) n = n + PW'(x[k]);
    return n;
  endfunction

endpackage

@@ sv/gmug_in_if.sv @@
// ----------------------------------------------------------------------------
// gmug_in_if
// Load word channel: valid/ready with feature, word, bits and done flag.
// ----------------------------------------------------------------------------
interface gmug_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  feature_index;
  logic [3:0]  word_index;
  logic [63:0] bits;
  logic        load_done;

  modport source (output valid, feature_index, word_index, bits, load_done,
                  input ready);
  modport sink   (input valid, feature_index, word_index, bits, load_done,
                  output ready);
endinterface

@@ sv/gmug_out_if.sv @@
// ----------------------------------------------------------------------------
// gmug_out_if
// Pick result channel: valid/ready with order position and group data.
// ----------------------------------------------------------------------------
interface gmug_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  order_index;
  logic [4:0]  chosen_feature;
  logic [10:0] group_union_count;
  logic        group_end;
  logic        last;

  modport source (output valid, order_index, chosen_feature, group_union_count,
                  group_end, last, input ready);
  modport sink   (input valid, order_index, chosen_feature, group_union_count,
                  group_end, last, output ready);
endinterface

@@ sv/greedy_min_union_grouping_core.sv @@
// ----------------------------------------------------------------------------
// greedy_min_union_grouping_core
// Stores per-feature activation bitsets, then orders features greedily into
// groups by smallest union popcount, one result per pick.
// ----------------------------------------------------------------------------
//  channel   dir  content
//  in_ch     in   feature_index, word_index, bits, load_done
//  out_ch    out  order_index, chosen_feature, group_union_count, group_end, last
//
//  Load words transfer one per cycle while idle.
//  A pick scans every remaining candidate through the single store read port,
//  then merges the best candidate into the group union and swaps it out of
//  the list, then waits in the output state until the result transfers.
//  Input is stalled from the load_done transfer until the last result transfers.
//  Reset (synchronous, rst_n low) restores the run state; the store is not
//  cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module greedy_min_union_grouping_core (
  input  logic        clk,
  input  logic        rst_n,
  gmug_in_if.sink     in_ch,
  gmug_out_if.source  out_ch
);

  localparam int FW  = gmug_pkg::FW;
  localparam int CW  = gmug_pkg::CW;
  localparam int SAW = gmug_pkg::SAW;
  localparam int GW  = gmug_pkg::GW;
  localparam int UCW = gmug_pkg::UCW;
  localparam int FIW = gmug_pkg::FIW;
  localparam int WIW = gmug_pkg::WIW;

  gmug_pkg::state_t state_r, state_nxt;

  logic [63:0]  store_mem [gmug_pkg::FEATURES*gmug_pkg::WORDS];
  logic [63:0]  un_mem    [gmug_pkg::WORDS];
  logic [gmug_pkg::WORDS-1:0] un_vld_r;
  logic [FIW-1:0] list_mem [gmug_pkg::FEATURES];
  logic [gmug_pkg::FEATURES-1:0] list_vld_r;

  logic [63:0]    st_q, un_q;
  logic [FIW-1:0] lst_q;
  logic [CW-1:0]  cnt_r, i_r;
  logic [FIW-1:0] f_r, best_f_r, best_i_r;
  logic [WIW-1:0] w_r, wd_r;
  logic           pv_r;
  logic [UCW-1:0] acc_r, best_r;
  logic [GW-1:0]  picks_r;
  logic [FW-1:0]  pos_r;

  logic           out_v_r, ge_r, last_r;
  logic [FW-1:0]  oi_r, cf_r;
  logic [UCW-1:0] guc_r;

  // control decoded from state
  logic           w_end, issue_st, list_rd;
  logic [SAW-1:0] st_addr;
  logic [FIW-1:0] list_addr;
  logic [UCW-1:0] total;

  assign w_end = (w_r == WIW'(gmug_pkg::WORDS - 1));
  assign total = acc_r + UCW'(gmug_pkg::pop64(st_q | un_q));

  always_comb begin
    state_nxt = state_r;
    issue_st  = 1'b0;
    list_rd   = 1'b0;
    st_addr   = SAW'({f_r, w_r});
    list_addr = i_r[FIW-1:0];
    case (state_r)
      gmug_pkg::S_IDLE: begin
        if (in_ch.valid && in_ch.load_done) state_nxt = gmug_pkg::S_LIST;
      end
      gmug_pkg::S_LIST: begin
        list_rd   = 1'b1;
        state_nxt = gmug_pkg::S_LREAD;
      end
      gmug_pkg::S_LREAD: state_nxt = gmug_pkg::S_SCAN;
      gmug_pkg::S_SCAN: begin
        issue_st = 1'b1;
        if (w_end) state_nxt = gmug_pkg::S_CMP;
      end
      gmug_pkg::S_CMP: begin
        if (i_r + CW'(1) == cnt_r) state_nxt = gmug_pkg::S_MRG;
        else                       state_nxt = gmug_pkg::S_LIST;
      end
      gmug_pkg::S_MRG: begin
        issue_st = 1'b1;
        st_addr  = SAW'({best_f_r, w_r});
        if (w_end) state_nxt = gmug_pkg::S_MWAIT;
      end
      gmug_pkg::S_MWAIT: begin
        list_rd   = 1'b1;
        list_addr = FIW'(cnt_r - CW'(1));
        state_nxt = gmug_pkg::S_SWAP;
      end
      gmug_pkg::S_SWAP: state_nxt = gmug_pkg::S_OUT;
      gmug_pkg::S_OUT: begin
        if (out_ch.ready) begin
          if (cnt_r == CW'(1)) state_nxt = gmug_pkg::S_IDLE;
          else                 state_nxt = gmug_pkg::S_LIST;
        end
      end
      default: state_nxt = gmug_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gmug_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == gmug_pkg::S_IDLE && in_ch.valid &&
        32'(in_ch.feature_index) < gmug_pkg::FEATURES &&
        32'(in_ch.word_index) < gmug_pkg::WORDS)
      store_mem[SAW'({in_ch.feature_index[FIW-1:0], in_ch.word_index[WIW-1:0]})]
        <= in_ch.bits;
    st_q <= store_mem[st_addr];
    un_q <= un_vld_r[w_r] ? un_mem[w_r] : 64'd0;
    if (pv_r && (state_r == gmug_pkg::S_MRG || state_r == gmug_pkg::S_MWAIT))
      un_mem[wd_r] <= st_q | un_q;
    if (list_rd)
      lst_q <= list_vld_r[list_addr] ? list_mem[list_addr] : list_addr;
    if (state_r == gmug_pkg::S_SWAP) list_mem[best_i_r] <= lst_q;
  end

  // datapath and run control
  always_ff @(posedge clk) begin
    pv_r <= issue_st;
    wd_r <= w_r;
    if (!rst_n) begin
      un_vld_r   <= '0;
      list_vld_r <= '0;
      cnt_r      <= CW'(gmug_pkg::FEATURES);
      picks_r    <= '0;
      pos_r      <= '0;
      i_r        <= '0;
      out_v_r    <= 1'b0;
    end else begin
      case (state_r)
        gmug_pkg::S_IDLE: begin
          i_r <= '0;
        end
        gmug_pkg::S_LIST: acc_r <= '0;
        gmug_pkg::S_LREAD: begin
          f_r <= lst_q;
          w_r <= '0;
        end
        gmug_pkg::S_SCAN: begin
          if (pv_r) acc_r <= total;
          w_r <= w_end ? '0 : w_r + WIW'(1);
        end
        gmug_pkg::S_CMP: begin
          if (i_r == '0 || total < best_r) begin
            best_r   <= total;
            best_i_r <= i_r[FIW-1:0];
            best_f_r <= f_r;
          end
          i_r <= i_r + CW'(1);
        end
        gmug_pkg::S_MRG: begin
          if (pv_r) un_vld_r[wd_r] <= 1'b1;
          w_r <= w_end ? '0 : w_r + WIW'(1);
        end
        gmug_pkg::S_MWAIT: un_vld_r[wd_r] <= 1'b1;
        gmug_pkg::S_SWAP: begin
          list_vld_r[best_i_r] <= 1'b1;
          out_v_r <= 1'b1;
          oi_r    <= pos_r;
          cf_r    <= best_f_r;
          ge_r    <= (picks_r == GW'(gmug_pkg::GROUP_SIZE - 1));
          guc_r   <= (picks_r == GW'(gmug_pkg::GROUP_SIZE - 1)) ? best_r : '0;
          last_r  <= (cnt_r == CW'(1));
        end
        gmug_pkg::S_OUT: begin
          if (out_ch.ready) begin
            out_v_r <= 1'b0;
            i_r     <= '0;
            if (cnt_r == CW'(1)) begin
              un_vld_r   <= '0;
              list_vld_r <= '0;
              cnt_r      <= CW'(gmug_pkg::FEATURES);
              picks_r    <= '0;
              pos_r      <= '0;
            end else begin
              cnt_r <= cnt_r - CW'(1);
              pos_r <= pos_r + FW'(1);
              // new group starts with an empty union
              if (picks_r == GW'(gmug_pkg::GROUP_SIZE - 1)) begin
                picks_r  <= '0;
                un_vld_r <= '0;
              end else begin
                picks_r <= picks_r + GW'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready              = (state_r == gmug_pkg::S_IDLE);
  assign out_ch.valid             = out_v_r;
  assign out_ch.order_index       = oi_r;
  assign out_ch.chosen_feature    = cf_r;
  assign out_ch.group_union_count = guc_r;
  assign out_ch.group_end         = ge_r;
  assign out_ch.last              = last_r;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("result pending while input ready");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(gmug_pkg::FEATURES)) && (cnt_r != '0))
    else $error("remaining count out of range");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("not idle after last transfer");
  a_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.group_end) |-> (out_ch.group_union_count == '0))
    else $error("union count without group end");
`endif

endmodule

@@ test/greedy_min_union_grouping_core_tb.sv @@
// ----------------------------------------------------------------------------
// greedy_min_union_grouping_core_tb
// Loads activation bitsets, triggers greedy grouping runs and checks every
// pick (order, feature, group end, union count, last) against a local model.
// ----------------------------------------------------------------------------
module greedy_min_union_grouping_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]  feature_index;
    logic [3:0]  word_index;
    logic [63:0] bits;
    logic        load_done;
  } load_word_t;

  typedef struct packed {
    logic [4:0]  order_index;
    logic [4:0]  chosen_feature;
    logic [10:0] group_union_count;
    logic        group_end;
    logic        last;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gmug_in_if  in_ch ();
  gmug_out_if out_ch ();

  greedy_min_union_grouping_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  load_word_t pending_words[$];
  pick_t      expected_picks[$];
  logic [63:0] bitset_mem [gmug_pkg::FEATURES][gmug_pkg::WORDS];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   hold_off_cycles = 0;
  int   hold_len = 0;
  bit   hold_req = 1'b0;
  bit   hold_seen = 1'b0;
  bit   in_taken = 1'b0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic int union_pop(input logic [63:0] acc[gmug_pkg::WORDS],
                                   input int f);
    int n;
    n = 0;
    for (int w = 0; w < gmug_pkg::WORDS; w++)
      n += $countones(acc[w] | bitset_mem[f][w]);
    return n;
  endfunction

  task automatic predict_grouping(input load_word_t lw);
    logic [63:0] acc[gmug_pkg::WORDS];
    int order_list[gmug_pkg::FEATURES];
    int left, in_group, best, best_i, c, f;
    pick_t p;
    if (lw.feature_index < gmug_pkg::FEATURES && lw.word_index < gmug_pkg::WORDS)
      bitset_mem[lw.feature_index][lw.word_index] = lw.bits;
    if (!lw.load_done) return;
    for (int i = 0; i < gmug_pkg::FEATURES; i++) order_list[i] = i;
    for (int w = 0; w < gmug_pkg::WORDS; w++) acc[w] = '0;
    left = gmug_pkg::FEATURES;
    in_group = 0;
    for (int pos = 0; pos < gmug_pkg::FEATURES; pos++) begin
      if (in_group >= gmug_pkg::GROUP_SIZE) begin
        for (int w = 0; w < gmug_pkg::WORDS; w++) acc[w] = '0;
        in_group = 0;
      end
      best = 0;
      best_i = 0;
      for (int i = 0; i < left; i++) begin
        c = union_pop(acc, order_list[i]);
        if (i == 0 || c < best) begin
          best = c;
          best_i = i;
        end
      end
      f = order_list[best_i];
      for (int w = 0; w < gmug_pkg::WORDS; w++) acc[w] |= bitset_mem[f][w];
      order_list[best_i] = order_list[left - 1];
      left--;
      p.order_index = 5'(pos);
      p.chosen_feature = 5'(f);
      p.group_end = (in_group == gmug_pkg::GROUP_SIZE - 1);
      p.group_union_count = p.group_end ? 11'((best > 2047) ? 2047 : best) : '0;
      p.last = (left == 0);
      expected_picks = {expected_picks, p};
      in_group++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: idle gaps, mostly short
  // --------------------------------------------------------------------------
  int send_gap = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input transfer seen at the rising edge, consumed by the driver at the next
  // falling edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.feature_index <= '0;
      in_ch.word_index    <= '0;
      in_ch.bits          <= '0;
      in_ch.load_done     <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold item until transfer
    end else begin
      if (in_taken) predict_grouping(pending_words.pop_front());
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.feature_index, in_ch.word_index, in_ch.bits, in_ch.load_done}
          <= pending_words[0];
        send_gap <= rand_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stalls, with a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= 0;
      hold_seen <= hold_req;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off_cycles <= hold_len;
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (rand_gap() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pick_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.order_index, out_ch.chosen_feature, out_ch.group_union_count,
             out_ch.group_end, out_ch.last};
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pick %p", got);
      end else begin
        want = expected_picks.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("pick mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("greedy_min_union_grouping_core_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_bits(input int density);
    logic [63:0] b;
    b = {$urandom, $urandom};
    case (density)
      0: b = b & {$urandom, $urandom} & {$urandom, $urandom};
      1: b = b | {$urandom, $urandom};
      default: ;
    endcase
    return b;
  endfunction

  task automatic queue_word(input int f, input int w, input logic [63:0] b,
                            input bit done);
    load_word_t lw;
    lw.feature_index = 5'(f);
    lw.word_index = 4'(w);
    lw.bits = b;
    lw.load_done = done;
    pending_words = {pending_words, lw};
  endtask

  // full load of every feature; each feature gets a random kind of pattern so
  // that ties (all zero), full unions (all ones) and random sets can show up
  task automatic queue_full_load();
    logic [63:0] b;
    int kind;
    for (int f = 0; f < gmug_pkg::FEATURES; f++) begin
      kind = $urandom_range(0, 4);
      for (int w = 0; w < gmug_pkg::WORDS; w++) begin
        case (kind)
          0: b = '0;
          1: b = '1;
          2: b = (w == 0) ? 64'(f + 1) : 64'h0;  // sparse, distinct
          default: b = rand_bits($urandom_range(0, 2));
        endcase
        queue_word(f, w, b, 1'b0);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_ch.valid || expected_picks.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: one full load, then short reloads queued back to back
    queue_full_load();
    queue_word(0, 0, '0, 1'b1);
    queue_word(31, 0, 64'h8000_0000_0000_0001, 1'b1);
    queue_word(5, 3, 64'hAAAA_5555_F0F0_0F0F, 1'b0);
    queue_word(0, 0, 64'h0123_4567_89AB_CDEF, 1'b1);
    queue_word(7, 15, '1, 1'b1);
    n = gmug_pkg::FEATURES * gmug_pkg::WORDS + 5;
    // long receiver hold-off once the first run starts, while loads pile up
    @(posedge clk);
    while (in_ch.ready !== 1'b0) @(posedge clk);
    hold_len = 3000;
    hold_req = ~hold_req;
    wait_drained();

    // random partial reloads, each followed by a run
    while (n < 560) begin
      repeat ($urandom_range(0, 5)) begin
        queue_word($urandom_range(0, 31), $urandom_range(0, 15),
                   rand_bits($urandom_range(0, 2)), 1'b0);
        n = n + 1;
      end
      queue_word($urandom_range(0, 31), $urandom_range(0, 15),
                 rand_bits($urandom_range(0, 2)), 1'b1);
      n = n + 1;
      if ($urandom_range(0, 3) == 0) begin
        hold_len = $urandom_range(200, 800);
        hold_req = ~hold_req;
      end
      wait_drained();
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_picks.size() == 0)
      $display("greedy_min_union_grouping_core_tb: PASS");
    else
      $display("greedy_min_union_grouping_core_tb: FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
sv/gmug_pkg.sv
sv/gmug_in_if.sv
sv/gmug_out_if.sv
sv/greedy_min_union_grouping_core.sv
test/greedy_min_union_grouping_core_tb.sv
